// ===== hw/rtl/lts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

   localparam int TABLE_DEPTH = 16;
   // compared key bits; at most the request's key width
   localparam int KEY_BITS    = 32;

   localparam int SCOPE_W = 16;
   localparam int STMT_W  = 16;
   localparam int KEY_W   = 32;
   localparam int TEMP_W  = 16;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [TEMP_W-1:0] TEMP_MAX = '1;

   typedef struct packed {
      logic [SCOPE_W-1:0] scope_id;
      logic [STMT_W-1:0]  stmt_number;
      logic [KEY_W-1:0]   type_key;
   } lts_req_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_number;
      logic              created;
   } lts_result_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [STMT_W-1:0]   stmt;
      logic [TEMP_W-1:0]   temp;
   } lts_entry_type;

   typedef struct packed {
      logic          we;
      logic [IDX_W-1:0] waddr;
      lts_entry_type wdata;
      logic [IDX_W-1:0] raddr;
   } lts_mem_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SRCH,
      ST_SHIFT
   } lts_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lts_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lts_req_if;
   logic                           valid;
   logic                           ready;
   logic [lts_pkg::SCOPE_W-1:0]    scope_id;
   logic [lts_pkg::STMT_W-1:0]     stmt_number;
   logic [lts_pkg::KEY_W-1:0]      type_key;

   modport source (output valid, output scope_id, output stmt_number, output type_key,
                   input ready);
   modport sink   (input valid, input scope_id, input stmt_number, input type_key,
                   output ready);
endinterface

interface lts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lts_pkg::TEMP_W-1:0]  temp_number;
   logic                        created;

   modport source (output valid, output temp_number, output created, input ready);
   modport sink   (input valid, input temp_number, input created, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lts_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lts_table (
   input  wire logic                     clock,
   input  wire lts_pkg::lts_mem_ctl_type mem_ctl,
   output lts_pkg::lts_entry_type        rd_data
);

   lts_pkg::lts_entry_type mem [lts_pkg::TABLE_DEPTH];
   lts_pkg::lts_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.we) begin
         mem[mem_ctl.waddr] <= mem_ctl.wdata;
      end
      rd_data_ff <= mem[mem_ctl.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lts_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire lts_pkg::lts_req_type     req,
   input  wire logic                     res_ready,
   output logic                          res_valid,
   output lts_pkg::lts_result_type       res,
   output lts_pkg::lts_mem_ctl_type      mem_ctl,
   input  wire lts_pkg::lts_entry_type   rd_data
);

   localparam int CW = lts_pkg::CNT_W;
   localparam int IW = lts_pkg::IDX_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(lts_pkg::TABLE_DEPTH);

   lts_pkg::lts_state_type state_ff, state_in;

   logic [CW-1:0]                    idx_ff, idx_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [lts_pkg::TEMP_W-1:0]       last_temp_ff, last_temp_in;
   logic [lts_pkg::SCOPE_W-1:0]      last_scope_ff, last_scope_in;
   logic                             scope_valid_ff, scope_valid_in;
   logic [lts_pkg::STMT_W-1:0]       stmt_ff, stmt_in;
   logic [lts_pkg::KEY_BITS-1:0]     key_ff, key_in;
   logic [lts_pkg::TEMP_W-1:0]       tnum_ff, tnum_in;
   logic                             created_ff, created_in;

   logic [CW-1:0] idx_p1, idx_p2, from_idx, from_p1;
   logic          hit, full;

   assign idx_p1   = idx_ff + CW'(1);
   assign idx_p2   = idx_ff + CW'(2);
   assign full     = (count_ff == DEPTH_C);
   assign from_idx = full ? '0 : count_ff;
   assign from_p1  = from_idx + CW'(1);
   // entries already used by this statement are skipped
   assign hit      = (rd_data.stmt != stmt_ff) && (rd_data.key == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lts_pkg::ST_IDLE;
         count_ff       <= '0;
         last_temp_ff   <= '0;
         last_scope_ff  <= '0;
         scope_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         last_temp_ff   <= last_temp_in;
         last_scope_ff  <= last_scope_in;
         scope_valid_ff <= scope_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      stmt_ff    <= stmt_in;
      key_ff     <= key_in;
      tnum_ff    <= tnum_in;
      created_ff <= created_in;
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      last_temp_in   = last_temp_ff;
      last_scope_in  = last_scope_ff;
      scope_valid_in = scope_valid_ff;
      stmt_in        = stmt_ff;
      key_in         = key_ff;
      tnum_in        = tnum_ff;
      created_in     = created_ff;

      req_ready       = 1'b0;
      res_valid       = 1'b0;
      res.temp_number = tnum_ff;
      res.created     = created_ff;

      mem_ctl.we         = 1'b0;
      mem_ctl.waddr      = idx_ff[IW-1:0];
      mem_ctl.wdata.key  = rd_data.key;
      mem_ctl.wdata.stmt = rd_data.stmt;
      mem_ctl.wdata.temp = rd_data.temp;
      mem_ctl.raddr      = idx_p1[IW-1:0];

      case (state_ff)
         lts_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            mem_ctl.raddr = '0;
            if (req_valid) begin
               stmt_in = req.stmt_number;
               key_in  = req.type_key[lts_pkg::KEY_BITS-1:0];
               idx_in  = '0;
               if (!scope_valid_ff || (req.scope_id != last_scope_ff)) begin
                  count_in       = '0;
                  last_temp_in   = '0;
                  last_scope_in  = req.scope_id;
                  scope_valid_in = 1'b1;
               end
               state_in = lts_pkg::ST_SRCH;
            end
         end

         // one entry compared per cycle; read of the next entry is in flight
         lts_pkg::ST_SRCH: begin
            if (idx_ff == count_ff) begin
               if (!full) begin
                  count_in = count_ff + CW'(1);
               end
               if (last_temp_ff != lts_pkg::TEMP_MAX) begin
                  last_temp_in = last_temp_ff + lts_pkg::TEMP_W'(1);
                  tnum_in      = last_temp_ff + lts_pkg::TEMP_W'(1);
               end else begin
                  tnum_in = last_temp_ff;
               end
               created_in    = 1'b1;
               idx_in        = from_idx;
               mem_ctl.raddr = from_p1[IW-1:0];
               state_in      = lts_pkg::ST_SHIFT;
            end else if (hit) begin
               tnum_in    = rd_data.temp;
               created_in = 1'b0;
               state_in   = lts_pkg::ST_SHIFT;
            end else begin
               idx_in = idx_p1;
            end
         end

         // close the gap one entry per cycle, then write the request's entry at the MRU end
         lts_pkg::ST_SHIFT: begin
            if (idx_p1 < count_ff) begin
               mem_ctl.we    = 1'b1;
               idx_in        = idx_p1;
               mem_ctl.raddr = idx_p2[IW-1:0];
            end else if (res_ready) begin
               mem_ctl.we         = 1'b1;
               mem_ctl.wdata.key  = key_ff;
               mem_ctl.wdata.stmt = stmt_ff;
               mem_ctl.wdata.temp = tnum_ff;
               res_valid          = 1'b1;
               state_in           = lts_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lts_pkg::ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lts_pkg::ST_SHIFT) |-> (idx_ff < count_ff))
      else $error("shift index outside valid entries");

   a_result_nonempty: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (count_ff != '0) && mem_ctl.we && (tnum_ff != '0))
      else $error("result issued without a table entry");

   a_temp_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lts_pkg::ST_IDLE) |=> (last_temp_ff >= $past(last_temp_ff)))
      else $error("temp counter went backwards inside a scope");

   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == lts_pkg::ST_SRCH) && (idx_ff == '0))
      else $error("accepted beat did not start a search");

endmodule

`default_nettype wire

// ===== hw/rtl/lru_temp_slot_reuse.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Temp slot allocator with an LRU reuse table of lts_pkg::TABLE_DEPTH entries. A request
// with a new scope id (or the first after reset) clears the table and the temp counter.
// Each request gets one response: a reused temp of matching type key that the same
// statement has not used yet (oldest first), or a freshly numbered temp (saturating at
// 65535), with created set. The block handles one request at a time; the entry table,
// with one read and one write per cycle, is walked one entry per cycle for the key
// search and again for the LRU shift.
// A finished response sits in an output register, so a new request is taken while it
// waits.
module lru_temp_slot_reuse (
   input  wire logic clock,
   input  wire logic reset,
   lts_req_if.sink   req_bus,
   lts_rsp_if.source rsp_bus
);

   lts_pkg::lts_req_type     req;
   lts_pkg::lts_result_type  res;
   lts_pkg::lts_mem_ctl_type mem_ctl;
   lts_pkg::lts_entry_type   rd_data;
   logic                     res_valid, res_ready;

   logic                     rsp_valid_ff, rsp_valid_in;
   lts_pkg::lts_result_type  rsp_data_ff;

   assign req.scope_id    = req_bus.scope_id;
   assign req.stmt_number = req_bus.stmt_number;
   assign req.type_key    = req_bus.type_key;

   lts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req       (req),
      .res_ready (res_ready),
      .res_valid (res_valid),
      .res       (res),
      .mem_ctl   (mem_ctl),
      .rd_data   (rd_data)
   );

   lts_table u_table (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_data (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.temp_number = rsp_data_ff.temp_number;
   assign rsp_bus.created     = rsp_data_ff.created;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int RAND_ITEMS  = 1120;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_SHOWN   = 10;

   typedef struct {
      lts_pkg::lts_req_type    rq;
      bit                      typed;
      lts_pkg::lts_result_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   lts_req_if req_if ();
   lts_rsp_if rsp_if ();

   lru_temp_slot_reuse u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // predictor state
   logic [lts_pkg::KEY_BITS-1:0] tbl_key  [lts_pkg::TABLE_DEPTH];
   logic [lts_pkg::STMT_W-1:0]   tbl_stmt [lts_pkg::TABLE_DEPTH];
   logic [lts_pkg::TEMP_W-1:0]   tbl_temp [lts_pkg::TABLE_DEPTH];
   int                           tbl_used;
   logic [lts_pkg::TEMP_W-1:0]   temp_ctr;
   logic [lts_pkg::SCOPE_W-1:0]  cur_scope;
   bit                           cur_scope_ok;

   lts_pkg::lts_result_type pending_temps [$];
   stim_row_type            dir_rows [$];

   int  mismatches;
   int  cycles;
   int  sender_mode;
   bit  hold_req;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic int pick_gap(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0) return 0;
      if (r < ((mode == 1) ? 80 : 50)) return 0;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void shift_entries(input int from);
      int j;
      for (j = from; j + 1 < tbl_used; j++) begin
         tbl_key[j]  = tbl_key[j+1];
         tbl_stmt[j] = tbl_stmt[j+1];
         tbl_temp[j] = tbl_temp[j+1];
      end
   endfunction

   // temp allocation: reuse the oldest same-type entry not used by this statement
   function automatic lts_pkg::lts_result_type alloc_temp(input lts_pkg::lts_req_type rq);
      logic [lts_pkg::KEY_BITS-1:0] k;
      int                           hit;
      int                           i;
      lts_pkg::lts_result_type      res;
      k = rq.type_key[lts_pkg::KEY_BITS-1:0];
      if (!cur_scope_ok || rq.scope_id != cur_scope) begin
         tbl_used     = 0;
         temp_ctr     = '0;
         cur_scope    = rq.scope_id;
         cur_scope_ok = 1'b1;
      end
      hit = -1;
      for (i = 0; i < tbl_used; i++) begin
         if (hit < 0 && tbl_stmt[i] != rq.stmt_number && tbl_key[i] == k) hit = i;
      end
      if (hit < 0) begin
         if (tbl_used == lts_pkg::TABLE_DEPTH) shift_entries(0);
         else tbl_used++;
         if (temp_ctr != lts_pkg::TEMP_MAX) temp_ctr++;
         res.temp_number = temp_ctr;
         res.created     = 1'b1;
      end else begin
         res.temp_number = tbl_temp[hit];
         res.created     = 1'b0;
         shift_entries(hit);
      end
      tbl_key[tbl_used-1]  = k;
      tbl_stmt[tbl_used-1] = rq.stmt_number;
      tbl_temp[tbl_used-1] = res.temp_number;
      return res;
   endfunction

   function automatic void add_row(input logic [15:0] sc, input logic [15:0] st,
                                   input logic [31:0] k, input bit typed,
                                   input logic [15:0] t, input bit c);
      stim_row_type row;
      row.rq.scope_id         = sc;
      row.rq.stmt_number      = st;
      row.rq.type_key         = k;
      row.typed               = typed;
      row.want.temp_number    = t;
      row.want.created        = c;
      dir_rows.push_back(row);
   endfunction

   function automatic void build_rows();
      int i;
      // scope 0 matches the reset value, still a fresh scope
      add_row(16'h0000, 16'h0001, 32'h0000_0005, 1, 16'd1, 1'b1);
      add_row(16'h0000, 16'h0002, 32'h0000_0005, 1, 16'd1, 1'b0);
      // same statement already holds it
      add_row(16'h0000, 16'h0002, 32'h0000_0005, 1, 16'd2, 1'b1);
      // two candidates, oldest wins
      add_row(16'h0000, 16'h0003, 32'h0000_0005, 0, 16'd0, 1'b0);
      add_row(16'h0000, 16'h0000, 32'h0000_0000, 1, 16'd3, 1'b1);
      add_row(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1, 16'd4, 1'b1);
      add_row(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 16'd1, 1'b1);
      add_row(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1, 16'd1, 1'b0);
      // fill the table and push one past it
      for (i = 0; i <= lts_pkg::TABLE_DEPTH; i++)
         add_row(16'h5A5A, 16'(10 + i), 32'(32'h100 + i), 1, 16'(i + 1), 1'b1);
      add_row(16'h5A5A, 16'd100, 32'h0000_0108, 1, 16'd9, 1'b0);
      add_row(16'h5A5A, 16'd101, 32'h0000_0100, 1, 16'(lts_pkg::TABLE_DEPTH + 2), 1'b1);
      add_row(16'h5A5A, 16'd102, 32'h0000_0108, 0, 16'd0, 1'b0);
   endfunction

   task automatic send_req(input lts_pkg::lts_req_type rq, input bit typed,
                           input lts_pkg::lts_result_type want);
      int                      gap;
      lts_pkg::lts_result_type got;
      gap = pick_gap(sender_mode);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.scope_id    <= rq.scope_id;
      req_if.stmt_number <= rq.stmt_number;
      req_if.type_key    <= rq.type_key;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      got = alloc_temp(rq);
      pending_temps.push_back(typed ? want : got);
   endtask

   // result checker
   always @(posedge clock) begin
      lts_pkg::lts_result_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_temps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected beat: temp_number=%0d created=%0d",
                        rsp_if.temp_number, rsp_if.created);
         end else begin
            w = pending_temps.pop_front();
            if (w.temp_number !== rsp_if.temp_number || w.created !== rsp_if.created) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("mismatch: temp_number exp %0d got %0d, created exp %0d got %0d",
                           w.temp_number, rsp_if.temp_number, w.created, rsp_if.created);
            end
         end
      end
   end

   // receiver: random stalls, calm stretches, one long hold-off
   initial begin
      int stall;
      int mode;
      int tick;
      stall = 0;
      mode  = 0;
      tick  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (tick == 0) begin
            mode = $urandom_range(0, 3);
            tick = $urandom_range(50, 400);
         end
         tick--;
         if (hold_req) begin
            hold_req = 1'b0;
            stall    = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall = pick_gap(mode);
         end
      end
   end

   initial begin
      int                          i;
      int                          sent;
      int                          pool_n;
      int                          run;
      logic [31:0]                 pool [24];
      logic [lts_pkg::SCOPE_W-1:0] scope;
      logic [lts_pkg::STMT_W-1:0]  stmt;
      lts_pkg::lts_req_type        rq;
      lts_pkg::lts_result_type     none;

      none               = '0;
      mismatches         = 0;
      cycles             = 0;
      sender_mode        = 1;
      hold_req           = 1'b0;
      tbl_used           = 0;
      temp_ctr           = '0;
      cur_scope          = '0;
      cur_scope_ok       = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.scope_id    = '0;
      req_if.stmt_number = '0;
      req_if.type_key    = '0;
      build_rows();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) send_req(dir_rows[r].rq, dir_rows[r].typed, dir_rows[r].want);

      sent  = 0;
      scope = 16'h0F0F;
      while (sent < RAND_ITEMS) begin
         if ($urandom_range(0, 99) < 85) scope = 16'($urandom_range(0, 65535));
         pool_n = $urandom_range(1, 24);
         for (i = 0; i < pool_n; i++) begin
            pool[i] = $urandom;
            // near-miss keys differ in a single bit
            if (i > 0 && $urandom_range(0, 4) == 0)
               pool[i] = pool[i-1] ^ (32'h1 << $urandom_range(0, 31));
         end
         run  = $urandom_range(4, 60);
         stmt = 16'($urandom_range(0, 65535));
         for (i = 0; i < run && sent < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 9) < 3) stmt++;
            if ($urandom_range(0, 99) < 6) begin
               rq.scope_id    = 16'($urandom_range(0, 65535));
               rq.stmt_number = 16'($urandom_range(0, 65535));
               rq.type_key    = $urandom;
            end else begin
               rq.scope_id    = scope;
               rq.stmt_number = stmt;
               rq.type_key    = pool[$urandom_range(0, pool_n - 1)];
            end
            if (sent % 40 == 0) sender_mode = $urandom_range(0, 3);
            if (sent == 250) hold_req = 1'b1;
            send_req(rq, 0, none);
            sent++;
         end
      end
      req_if.valid <= 1'b0;

      while (pending_temps.size() > 0) @(posedge clock);
      repeat (2 * lts_pkg::TABLE_DEPTH + 10) @(posedge clock);
      if (mismatches == 0 && pending_temps.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
